[sv/sha256_stream_hash_defines.svh]
// Assertion macros for the streaming hash block.
`ifndef SHA256_STREAM_HASH_DEFINES_SVH
`define SHA256_STREAM_HASH_DEFINES_SVH
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[sv/sha_pkg.sv]
// Types, constants and round functions shared by the hash block.
package sha_pkg;
    localparam int unsigned BlockBytes = 64;
    localparam int unsigned LenBytes   = 8;
    localparam int unsigned Rounds     = 64;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } t_out_item;

    typedef struct packed {
        logic start;
        logic init;
    } t_core_ctl;

    localparam logic [31:0] InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction
endpackage

[sv/sha_core.sv]
// Compression unit: one shared round datapath, one round per cycle, plus chain update.
module sha_core
    import sha_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_core_ctl       i_ctl,
    input  logic [511:0]    i_block,
    output logic            o_busy,
    output logic [255:0]    o_chain
);
    logic [6:0]  r_rnd;
    logic        r_busy;
    logic [31:0] r_w [16];
    logic [31:0] r_v [8];
    logic [31:0] r_h [8];
    logic [31:0] w_cur;
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [5:0]  rnd_idx;

    assign rnd_idx = r_rnd[5:0];
    assign w_cur = r_w[0];
    assign w_new = ssig1(r_w[14]) + r_w[9] + ssig0(r_w[1]) + r_w[0];
    assign t1 = r_v[7] + bsig1(r_v[4]) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
                + RoundK[rnd_idx] + w_cur;
    assign t2 = bsig0(r_v[0]) + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign o_busy = r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd  <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
        end else if (i_ctl.init) begin
            for (int i = 0; i < 8; i++) r_h[i] <= InitHash[i];
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_rnd  <= '0;
            for (int i = 0; i < 16; i++) r_w[i] <= i_block[511 - 32 * i -: 32];
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (r_busy) begin
            if (r_rnd == 7'(Rounds)) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                r_busy <= 1'b0;
            end else begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
                r_w[15] <= w_new;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
                r_rnd  <= r_rnd + 7'd1;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) o_chain[255 - 32 * i -: 32] = r_h[i];
    end
endmodule

[sv/sha256_stream_hash.sv]
// Streaming SHA-256: bytes in, eight digest words out per message.
// Each transfer carries at most one byte; a transfer that does not close the
// message leaves the input ready unless it fills a 64-byte block. That transfer
// holds the input off during compression: a start state for the single shared
// round unit, then one load, 64 rounds (one per cycle) and one chain update.
// A closing transfer runs one or two padding blocks (after the full block if its
// byte fills one), then emits eight words, one per accepted output transfer;
// input is not ready from the closing transfer until word 7 leaves.
module sha256_stream_hash
    import sha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);
    localparam logic [2:0] StIdle = 3'd0;
    localparam logic [2:0] StFull = 3'd1;
    localparam logic [2:0] StPad1 = 3'd2;
    localparam logic [2:0] StPad2 = 3'd3;
    localparam logic [2:0] StOut  = 3'd4;
    localparam logic [2:0] StWait = 3'd5;

    logic [2:0]   r_st;
    logic [7:0]   r_blk [64];
    logic [5:0]   r_cnt;
    logic [63:0]  r_bits;
    logic [2:0]   r_word;
    logic         r_two;
    logic         r_pad2;
    logic [511:0] blk_flat;
    logic [511:0] pad_flat;
    logic [255:0] chain;
    logic         busy;
    logic         start;
    t_core_ctl    ctl;
    logic         acc;
    logic         dlv;
    logic [5:0]   wr_idx;
    logic         r_fin;   // closing pending after current compression
    logic         r_run;   // core started, wait for busy

    assign o_ready = (r_st == StIdle);
    assign acc = i_valid && o_ready;
    assign o_valid = (r_st == StOut);
    assign dlv = o_valid && i_ready;
    assign wr_idx = r_cnt;

    always_comb begin
        for (int i = 0; i < 64; i++) blk_flat[511 - 8 * i -: 8] = r_blk[i];
    end

    // pad: bytes below count, 0x80 at count, zeros; 2nd pad all zero; length last
    always_comb begin
        for (int i = 0; i < 64; i++) begin
            if (r_pad2) pad_flat[511 - 8 * i -: 8] = 8'h00;
            else if (6'(i) < r_cnt) pad_flat[511 - 8 * i -: 8] = r_blk[i];
            else if (6'(i) == r_cnt) pad_flat[511 - 8 * i -: 8] = 8'h80;
            else pad_flat[511 - 8 * i -: 8] = 8'h00;
        end
        if (!r_two || r_pad2) pad_flat[63:0] = r_bits;
    end

    always_comb begin
        start = 1'b0;
        case (r_st)
            StFull, StPad1, StPad2: start = 1'b1;
            default: start = 1'b0;
        endcase
    end

    assign ctl.start = start;
    assign ctl.init = dlv && r_word == 3'd7;

    sha_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_block ((r_st == StFull) ? blk_flat : pad_flat),
        .o_busy  (busy),
        .o_chain (chain)
    );

    always_ff @(posedge i_clk) begin
        if (acc && i_data.has_byte) r_blk[wr_idx] <= i_data.msg_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle;
            r_cnt <= '0;
            r_bits <= '0;
            r_word <= '0;
            r_two <= 1'b0;
            r_pad2 <= 1'b0;
            r_fin <= 1'b0;
            r_run <= 1'b0;
        end else begin
            r_run <= start;
            case (r_st)
                StIdle: begin
                    if (acc) begin
                        if (i_data.has_byte) begin
                            r_cnt <= r_cnt + 6'd1;
                            r_bits <= r_bits + 64'd8;
                        end
                        r_pad2 <= 1'b0;
                        if (i_data.has_byte && r_cnt == 6'd63) begin
                            r_fin <= i_data.end_of_message;
                            r_st <= StFull;
                        end else if (i_data.end_of_message) begin
                            r_two <= (i_data.has_byte ? r_cnt + 6'd1 : r_cnt) >= 6'd56;
                            r_st <= StPad1;
                        end
                    end
                end
                StFull, StPad1, StPad2: r_st <= StWait;
                StWait: begin
                    if (!r_run && !busy) begin
                        if (r_fin) begin
                            r_fin <= 1'b0;
                            r_two <= (r_cnt >= 6'd56);
                            r_st <= StPad1;
                        end else if (r_two && !r_pad2 && r_st == StWait && r_word == 3'd1)
                            r_st <= StOut;
                        else if (r_two && !r_pad2) begin
                            r_pad2 <= 1'b1;
                            r_st <= StPad2;
                        end else if (r_pad2 || r_word == 3'd1) begin
                            r_st <= StOut;
                            r_word <= '0;
                        end else r_st <= StIdle;
                    end
                end
                StOut: begin
                    if (dlv) begin
                        r_word <= r_word + 3'd1;
                        if (r_word == 3'd7) begin
                            r_st <= StIdle;
                            r_cnt <= '0;
                            r_bits <= '0;
                            r_two <= 1'b0;
                            r_pad2 <= 1'b0;
                        end
                    end
                end
                default: r_st <= StIdle;
            endcase
            // mark a single pad block done for output routing; clear count on full
            if (r_st == StPad1 && !r_two) r_word <= 3'd1;
            if (r_st == StPad1 && r_two) r_word <= 3'd0;
            if (r_st == StFull) r_cnt <= '0;
        end
    end

    assign o_data.digest_word = chain[255 - 32 * r_word -: 32];
    assign o_data.word_number = r_word;
    assign o_data.last_word = (r_word == 3'd7);
endmodule

[sv/sha_checker.sv]
// Port-level checker for the streaming hash block, bound to the top level.
`include "sha256_stream_hash_defines.svh"
module sha_checker
    import sha_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_item  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_item o_data
);
    `SHA_ASSERT_IMPL(a_no_overlap, i_clk, i_rst_n, o_valid, !o_ready)
    `SHA_ASSERT_IMPL(a_last_flag, i_clk, i_rst_n, o_valid, o_data.last_word == (o_data.word_number == 3'd7))
    `SHA_ASSERT_NEXT(a_word_step, i_clk, i_rst_n, o_valid && i_ready && !o_data.last_word, o_valid && o_data.word_number == $past(o_data.word_number) + 3'd1)
    `SHA_ASSERT_NEXT(a_close_busy, i_clk, i_rst_n, i_valid && o_ready && i_data.end_of_message, !o_ready)
endmodule

bind sha256_stream_hash sha_checker u_sha_checker (.*);

[bench/tb_sha256_stream_hash.sv]
// Testbench for sha256_stream_hash: directed items and random byte streams checked against a SHA-256 predictor.
module tb_sha256_stream_hash;
    timeunit 1ns;
    timeprecision 1ps;
    import sha_pkg::*;

    class digest_board;
        logic [31:0] chain [8];
        logic [7:0]  blk [64];
        int unsigned fill;
        logic [63:0] bit_len;
        t_out_item   pending [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++) begin
                chain[i] = InitHash[i];
            end
            fill = 0;
            bit_len = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] x, int n);
            return (x >> n) | (x << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1, t2, e, a;
            for (int i = 0; i < 16; i++) begin
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            end
            for (int i = 16; i < 64; i++) begin
                w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                     + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
            end
            v = chain;
            for (int i = 0; i < 64; i++) begin
                a = v[0];
                e = v[4];
                t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
                   + RoundK[i] + w[i];
                t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) ^ 32'h0;
                t2 = t2 + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++) begin
                chain[i] = chain[i] + v[i];
            end
        endfunction

        function void note_input(t_in_item it);
            t_out_item o;
            if (it.has_byte) begin
                blk[fill] = it.msg_byte;
                fill++;
                bit_len += 8;
                if (fill == 64) begin
                    compress();
                    fill = 0;
                end
            end
            if (!it.end_of_message) return;
            blk[fill] = 8'h80;
            for (int i = fill + 1; i < 64; i++) blk[i] = 8'h00;
            if (fill >= 56) begin
                compress();
                for (int i = 0; i < 56; i++) blk[i] = 8'h00;
            end
            for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
            compress();
            for (int i = 0; i < 8; i++) begin
                o.digest_word = chain[i];
                o.word_number = 3'(i);
                o.last_word = (i == 7);
                pending.push_back(o);
            end
            restart();
        endfunction

        function void check_result(t_out_item got);
            t_out_item exp_w;
            if (pending.size() == 0) begin
                $error("unexpected digest word %h", got.digest_word);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got.digest_word !== exp_w.digest_word) begin
                $error("digest_word exp %h got %h", exp_w.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_number !== exp_w.word_number) begin
                $error("word_number exp %0d got %0d", exp_w.word_number, got.word_number);
                errors++;
            end
            if (got.last_word !== exp_w.last_word) begin
                $error("last_word exp %0d got %0d", exp_w.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_valid = 0;
    logic      o_ready;
    t_in_item  i_data = '0;
    logic      o_valid;
    logic      i_ready = 0;
    t_out_item o_data;

    digest_board board = new();
    bit          hold_rx = 0;
    bit          feed_done = 0;
    int          sent = 0;

    sha256_stream_hash u_top (.*);

    always #10 i_clk = ~i_clk;

    task automatic send_item(logic [7:0] b, logic hb, logic eom);
        int gap;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_data <= '{msg_byte: b, has_byte: hb, end_of_message: eom};
        do @(posedge i_clk); while (!o_ready);
        board.note_input(i_data);
        sent++;
    endtask

    task automatic send_message(int len);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 15) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, i == len - 1);
        end
        if (len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_item(8'hff, 0, 1);
        send_item(8'h00, 0, 0);
        send_item(8'h61, 1, 0);
        send_item(8'h62, 1, 0);
        send_item(8'h63, 1, 1);
        send_item(8'hff, 1, 0);
        send_item(8'h00, 1, 0);
        send_item(8'h5a, 0, 1);
        send_item(8'ha5, 1, 1);
        drain();
        send_message(55);
        send_message(56);
        send_message(64);
        drain();
        hold_rx = 1;
        send_message(3);
        send_message(2);
        hold_rx = 0;
        while (sent < 330) begin
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(50, 70);
                default: len = $urandom_range(0, 30);
            endcase
            send_message(len);
            if (len > 40) send_message($urandom_range(0, 4));
            if ($urandom_range(0, 5) == 0) drain();
            if (board.errors > 50) break;
            if ($urandom_range(0, 10) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            if ($urandom_range(0, 2) == 0 && board.pending.size() == 0) send_message(1);
        end
        drain();
        feed_done = 1;
    end

    initial begin : rx_side
        int gap;
        int stall;
        bit stalled;
        stalled = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_rx && !stalled) begin
                stalled = 1;
                i_ready <= 0;
                stall = 300;
                while (stall > 0) begin
                    @(posedge i_clk);
                    stall--;
                end
            end
            if (!hold_rx) stalled = 0;
            gap = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0) gap = 0;
            if (gap > 0) begin
                i_ready <= 0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1;
            do @(posedge i_clk); while (!o_valid);
            board.check_result(o_data);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
            if (feed_done) begin
                repeat (200) @(posedge i_clk);
                if (board.errors == 0 && board.pending.size() == 0) $display("PASS");
                else $display("FAIL");
                $finish;
            end else if (quiet >= 5000) begin
                $display("FAIL");
                $finish;
            end
        end
    end
endmodule

[filelist.f]
+incdir+sv
sv/sha_pkg.sv
sv/sha_core.sv
sv/sha256_stream_hash.sv
sv/sha_checker.sv
bench/tb_sha256_stream_hash.sv
